[rtl/obrb_pkg.sv]
// ----------------------------------------------------------------------------
// obrb_pkg: shared types and helpers for the overwriting byte ring buffer
// Holds sizing constants, command codes, the queued item type and pointer math.
// ----------------------------------------------------------------------------
package obrb_pkg;

  localparam int DEPTH       = 64;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int BYTE_W      = 8;
  localparam int CMD_W       = 2;
  localparam int LIMIT_W     = 6;
  localparam int FILL_W      = 6;
  localparam int MAX_RESULTS = 63;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int CMP_A_W     = (PTR_W > LIMIT_W) ? PTR_W : LIMIT_W;
  localparam int CMP_W       = (CMP_A_W > CNT_W) ? CMP_A_W : CNT_W;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    op_t                op;
    logic [BYTE_W-1:0]  data;
    logic [LIMIT_W-1:0] limit;
  } item_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == ptr_t'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Bytes stored between head and tail, wrapping at DEPTH.
  function automatic ptr_t fill_of(input ptr_t h, input ptr_t t);
    if (t >= h) begin
      return t - h;
    end
    return t - h + ptr_t'(DEPTH);
  endfunction

  function automatic logic [FILL_W-1:0] level_of(input ptr_t f);
    logic [31:0] w;
    w = 32'(f);
    return w[FILL_W-1:0];
  endfunction

endpackage

[rtl/obrb_front.sv]
// ----------------------------------------------------------------------------
// obrb_front: request intake
// Decodes the command into an operation and parks items in a two-entry queue.
// ----------------------------------------------------------------------------
module obrb_front
  import obrb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic [LIMIT_W-1:0] read_limit,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  item_t      slots [2];
  item_t      item_in;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;

  always_comb begin
    item_in.data  = data_byte;
    item_in.limit = read_limit;
    case (cmd)
      CMD_WRITE: item_in.op = OP_WRITE;
      CMD_READ:  item_in.op = OP_READ;
      CMD_CLEAR: item_in.op = OP_CLEAR;
      default:   item_in.op = OP_NOP;
    endcase
  end

  assign req_stall = (count == 2'd2);
  assign accept    = req_valid && !req_stall;
  assign q_valid   = (count != 2'd0);
  assign q_item    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({accept, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/obrb_back.sv]
// ----------------------------------------------------------------------------
// obrb_back: buffer execution
// Owns the byte store and pointers, runs each operation and drives results.
// ----------------------------------------------------------------------------
module obrb_back
  import obrb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               byte_valid,
  output logic               last,
  output logic [FILL_W-1:0]  fill_level,
  output logic               dropped_oldest
);

  typedef enum logic {
    IDLE,
    BURST
  } state_t;

  state_t            state;
  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data;
  ptr_t              head;
  ptr_t              tail;
  logic [CNT_W-1:0]  remaining;

  ptr_t              head_inc;
  ptr_t              tail_inc;
  ptr_t              fill_cur;
  logic              wr_drop;
  logic              out_free;
  logic              issue_byte;
  logic [CMP_W-1:0]  avail;
  logic [CMP_W-1:0]  lim;
  logic [CNT_W-1:0]  burst_len;

  assign head_inc = ptr_inc(head);
  assign tail_inc = ptr_inc(tail);
  assign fill_cur = fill_of(head, tail);
  assign wr_drop  = (tail_inc == head);
  assign out_free = !rsp_valid || !rsp_stall;
  assign q_pop    = (state == IDLE) && q_valid && out_free;

  assign issue_byte = out_free &&
                      ((state == BURST) ||
                       (q_pop && (q_item.op == OP_READ) && (fill_cur != '0)));

  // Burst length: fill, trimmed by a nonzero limit, capped at the result limit.
  always_comb begin
    avail = CMP_W'(fill_cur);
    lim   = CMP_W'(q_item.limit);
    if ((lim != '0) && (avail > lim)) begin
      avail = lim;
    end
    if (avail > CMP_W'(MAX_RESULTS)) begin
      avail = CMP_W'(MAX_RESULTS);
    end
    burst_len = avail[CNT_W-1:0];
  end

  assign out_byte = byte_valid ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (q_pop && (q_item.op == OP_WRITE)) begin
      mem[tail] <= q_item.data;
    end
    if (issue_byte) begin
      rd_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      head           <= '0;
      tail           <= '0;
      remaining      <= '0;
      rsp_valid      <= 1'b0;
      byte_valid     <= 1'b0;
      last           <= 1'b0;
      fill_level     <= '0;
      dropped_oldest <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (q_pop) begin
            rsp_valid <= 1'b1;
            case (q_item.op)
              OP_WRITE: begin
                tail           <= tail_inc;
                byte_valid     <= 1'b0;
                last           <= 1'b1;
                dropped_oldest <= wr_drop;
                if (wr_drop) begin
                  head       <= head_inc;
                  fill_level <= level_of(fill_of(head_inc, tail_inc));
                end else begin
                  fill_level <= level_of(fill_of(head, tail_inc));
                end
              end
              OP_READ: begin
                dropped_oldest <= 1'b0;
                if (fill_cur == '0) begin
                  byte_valid <= 1'b0;
                  last       <= 1'b1;
                  fill_level <= '0;
                end else begin
                  head       <= head_inc;
                  byte_valid <= 1'b1;
                  last       <= (burst_len == CNT_W'(1));
                  fill_level <= level_of(fill_of(head_inc, tail));
                  if (burst_len != CNT_W'(1)) begin
                    remaining <= burst_len - 1'b1;
                    state     <= BURST;
                  end
                end
              end
              OP_CLEAR: begin
                head           <= '0;
                tail           <= '0;
                byte_valid     <= 1'b0;
                last           <= 1'b1;
                dropped_oldest <= 1'b0;
                fill_level     <= '0;
              end
              default: begin
                byte_valid     <= 1'b0;
                last           <= 1'b1;
                dropped_oldest <= 1'b0;
                fill_level     <= level_of(fill_cur);
              end
            endcase
          end else if (out_free) begin
            rsp_valid <= 1'b0;
          end
        end
        BURST: begin
          if (out_free) begin
            rsp_valid      <= 1'b1;
            head           <= head_inc;
            byte_valid     <= 1'b1;
            dropped_oldest <= 1'b0;
            last           <= (remaining == CNT_W'(1));
            fill_level     <= level_of(fill_of(head_inc, tail));
            remaining      <= remaining - 1'b1;
            if (remaining == CNT_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/overwriting_byte_ring_buffer_core.sv]
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer_core: byte ring buffer that drops the oldest
// A result is registered in the back once its queued request beat is popped.
// Throughput when results are not stalled: one write, clear or empty read per
//   cycle; a read burst gives one byte per cycle out of the store's read port.
// Reset (rst, synchronous): pointers, queue and result valid clear at once;
//   the byte store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module overwriting_byte_ring_buffer_core
  import obrb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic [LIMIT_W-1:0] read_limit,
  // result channel
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               byte_valid,
  output logic               last,
  output logic [FILL_W-1:0]  fill_level,
  output logic               dropped_oldest
);

  // Decoded request beats waiting for the execution side.
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // Front: take request beats, decode the command, queue them.
  obrb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .read_limit (read_limit),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // Back: run writes, bursts and clears against the store; hold each result
  // beat in an output register until the consumer takes it.
  obrb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .last           (last),
    .fill_level     (fill_level),
    .dropped_oldest (dropped_oldest)
  );

endmodule

[bench/overwriting_byte_ring_buffer_core_tb.sv]
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer_core_tb: self-checking bench for the byte ring
// Drives write, read-burst, clear and unused commands through the request
// channel. A shadow ring in the bench predicts every result beat. Each beat
// on the result channel is checked field by field against the oldest
// prediction, under random idling on both sides and one long receiver hold.
// ----------------------------------------------------------------------------
module overwriting_byte_ring_buffer_core_tb;
  import obrb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Allow far more cycles than the slowest correct run needs.
  localparam int CYCLE_LIMIT  = 200_000;
  // Idle time after the last result beat before the next test starts.
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 400;

  // One result beat as the block reports it.
  typedef struct {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    logic [FILL_W-1:0] fill_level;
    logic              dropped_oldest;
  } result_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [CMD_W-1:0]   cmd = CMD_WRITE;
  logic [BYTE_W-1:0]  data_byte = '0;
  logic [LIMIT_W-1:0] read_limit = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [BYTE_W-1:0]  out_byte;
  logic               byte_valid;
  logic               last;
  logic [FILL_W-1:0]  fill_level;
  logic               dropped_oldest;

  // Shadow copy of the ring: byte slots plus head and tail pointers.
  logic [BYTE_W-1:0] ring_bytes [DEPTH];
  int                ring_head = 0;
  int                ring_tail = 0;

  // Result beats predicted but not yet seen, oldest first.
  result_beat_t pending_results [$];

  // Idle odds in percent for each side, and the remaining receiver hold.
  int req_idle_pct = 0;
  int rsp_stall_pct = 0;
  int hold_cycles = 0;

  int requests_sent = 0;
  int beats_checked = 0;
  int bytes_read = 0;
  int drops_seen = 0;
  int fail_count = 0;

  overwriting_byte_ring_buffer_core uut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .cmd            (cmd),
    .data_byte      (data_byte),
    .read_limit     (read_limit),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .last           (last),
    .fill_level     (fill_level),
    .dropped_oldest (dropped_oldest)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Bytes held between head and tail, wrapping at DEPTH.
  function automatic int ring_fill();
    return (ring_tail - ring_head + DEPTH) % DEPTH;
  endfunction

  // Queue one expected beat; the fill level is taken after the action.
  function automatic void push_result(logic [BYTE_W-1:0] b, logic valid_b,
                                      logic last_b, logic drop_b);
    result_beat_t beat;
    beat.out_byte       = b;
    beat.byte_valid     = valid_b;
    beat.last           = last_b;
    beat.fill_level     = FILL_W'(ring_fill());
    beat.dropped_oldest = drop_b;
    pending_results.push_back(beat);
  endfunction

  // Advance the shadow ring by one accepted request and queue its beats.
  function automatic void predict_ring_results(op_t op, logic [BYTE_W-1:0] data,
                                               logic [LIMIT_W-1:0] limit);
    int tail_after;
    int count;
    logic drop;
    case (op)
      OP_WRITE: begin
        // Store at tail; if tail would land on head, drop the oldest byte.
        ring_bytes[ring_tail] = data;
        tail_after = (ring_tail + 1) % DEPTH;
        drop = (tail_after == ring_head);
        if (drop) begin
          ring_head = (ring_head + 1) % DEPTH;
        end
        ring_tail = tail_after;
        push_result('0, 1'b0, 1'b1, drop);
      end
      OP_READ: begin
        count = ring_fill();
        if (count == 0) begin
          push_result('0, 1'b0, 1'b1, 1'b0);
        end else begin
          if (limit != 0 && count > int'(limit)) begin
            count = int'(limit);
          end
          if (count > MAX_RESULTS) begin
            count = MAX_RESULTS;
          end
          for (int i = 0; i < count; i++) begin
            data = ring_bytes[ring_head];
            ring_head = (ring_head + 1) % DEPTH;
            push_result(data, 1'b1, (i == count - 1), 1'b0);
          end
        end
      end
      OP_CLEAR: begin
        ring_head = 0;
        ring_tail = 0;
        push_result('0, 1'b0, 1'b1, 1'b0);
      end
      default: begin
        // Unused command: one clear-like beat, pointers untouched.
        push_result('0, 1'b0, 1'b1, 1'b0);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request beat, with random idle cycles first, and hold it until
  // accepted. Valid stays high afterwards so back-to-back beats need no dip.
  task automatic send_request(op_t op, logic [BYTE_W-1:0] data,
                              logic [LIMIT_W-1:0] limit);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    cmd        <= op;
    data_byte  <= data;
    read_limit <= limit;
    do @(posedge clk); while (req_stall);
    predict_ring_results(op, data, limit);
    requests_sent++;
  endtask

  // Read limit mix: read-all, the top value, small bursts, anything.
  function automatic logic [LIMIT_W-1:0] pick_read_limit();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return LIMIT_W'($urandom_range(1, 8));
      default: return LIMIT_W'($urandom);
    endcase
  endfunction

  // Drop valid and hold off until every predicted beat has arrived.
  task automatic wait_until_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Stall at random, or hold off completely while a long hold is running.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      rsp_stall <= 1'b1;
      hold_cycles--;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
    end
  end

  task automatic check_field(string name, logic [BYTE_W-1:0] want,
                             logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Pop the oldest prediction for every accepted result beat and compare.
  always @(posedge clk) begin
    result_beat_t want;
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: out_byte 0x%0h last %0b",
               out_byte, last);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_byte", want.out_byte, out_byte);
        check_field("byte_valid", BYTE_W'(want.byte_valid), BYTE_W'(byte_valid));
        check_field("last", BYTE_W'(want.last), BYTE_W'(last));
        check_field("fill_level", BYTE_W'(want.fill_level), BYTE_W'(fill_level));
        check_field("dropped_oldest", BYTE_W'(want.dropped_oldest),
                    BYTE_W'(dropped_oldest));
        beats_checked++;
        if (want.byte_valid) bytes_read++;
        if (want.dropped_oldest) drops_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty reads, the unused command, byte extremes, limits below and
  // above the fill, read-all, and a clear that leaves the ring empty.
  task automatic test_directed_cases();
    send_request(OP_READ,  8'hFF, '0);
    send_request(OP_READ,  8'h00, '1);
    send_request(OP_NOP,   8'hFF, '1);
    send_request(OP_WRITE, 8'h00, '1);
    send_request(OP_WRITE, 8'hFF, '0);
    send_request(OP_WRITE, 8'hA5, 6'h2A);
    send_request(OP_WRITE, 8'h5A, 6'h15);
    send_request(OP_READ,  8'hFF, 6'd1);
    send_request(OP_NOP,   8'h00, '0);
    send_request(OP_READ,  8'h00, '1);
    send_request(OP_WRITE, 8'h3C, '0);
    send_request(OP_WRITE, 8'hC3, '0);
    send_request(OP_READ,  8'h00, '0);
    send_request(OP_WRITE, 8'h11, '0);
    send_request(OP_WRITE, 8'h22, '0);
    send_request(OP_CLEAR, 8'hFF, '1);
    send_request(OP_READ,  8'h00, '0);
    send_request(OP_WRITE, 8'h77, '0);
    send_request(OP_READ,  8'h00, 6'd2);
    wait_until_drained();
  endtask

  // Hold the receiver off for a long stretch while writes keep coming: the
  // block backs up and stalls requests, the ring wraps and drops its oldest
  // bytes, and the read-all that follows is the longest burst possible.
  task automatic test_backpressure_fill();
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    hold_cycles   = HOLD_CYCLES;
    repeat (70) send_request(OP_WRITE, BYTE_W'($urandom), LIMIT_W'($urandom));
    send_request(OP_READ, BYTE_W'($urandom), '0);
    wait_until_drained();
  endtask

  // Mostly write runs followed by a read burst, with noise, clears and the
  // unused command mixed in. Some runs are long enough to overflow the ring.
  task automatic run_random_traffic(int n_requests);
    int target;
    int run_len;
    int pick;
    target = requests_sent + n_requests;
    while (requests_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                              : $urandom_range(1, 12);
        repeat (run_len) begin
          send_request(OP_WRITE, BYTE_W'($urandom), LIMIT_W'($urandom));
        end
        send_request(OP_READ, BYTE_W'($urandom), pick_read_limit());
      end else if (pick < 8) begin
        send_request(op_t'($urandom_range(0, 3)), BYTE_W'($urandom),
                     LIMIT_W'($urandom));
      end else if (pick == 8) begin
        send_request(OP_CLEAR, BYTE_W'($urandom), LIMIT_W'($urandom));
      end else begin
        send_request(OP_NOP, BYTE_W'($urandom), LIMIT_W'($urandom));
      end
    end
    wait_until_drained();
  endtask

  task automatic test_random_sparse_sender();
    req_idle_pct  = 12;
    rsp_stall_pct = 59;
    run_random_traffic(127);
  endtask

  task automatic test_random_sparse_receiver();
    req_idle_pct  = 59;
    rsp_stall_pct = 12;
    run_random_traffic(127);
  endtask

  task automatic test_random_full_rate();
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    run_random_traffic(127);
  endtask

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------

  // Abort a hung run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    req_idle_pct  = 12;
    rsp_stall_pct = 59;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_backpressure_fill();
    test_random_sparse_sender();
    test_random_sparse_receiver();
    test_random_full_rate();

    $display("Covered %0d requests: writes with overwrite, bursts, clears, unused cmd.",
             requests_sent);
    $display("Checked %0d result beats, %0d bytes read back, %0d oldest-byte drops.",
             beats_checked, bytes_read, drops_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
